/* src/ggvs_pkg.sv */
// Package for the greedy garbage-collection victim selector.
// Holds sizes, command codes, request and result types. No dependencies.
package ggvs_pkg;
	localparam int PKG_COUNT = 4;
	localparam int DIES_PER_PACKAGE = 2;
	localparam int BLOCKS_PER_DIE = 64;
	localparam int PAGES_PER_BLOCK = 64;
	localparam int DIE_COUNT = PKG_COUNT * DIES_PER_PACKAGE;
	localparam int NUM_BLOCKS = DIE_COUNT * BLOCKS_PER_DIE;
	localparam int SLOT_W = $clog2(NUM_BLOCKS);
	localparam int DSLOT_W = $clog2(DIE_COUNT);
	localparam int CNT_W = $clog2(BLOCKS_PER_DIE + 1);
	localparam int PV_W = 7;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_COMMIT = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_STATUS = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] pkg_index;
		logic any_package;
		logic die_index;
		logic any_die;
		logic [5:0] block_index;
		logic replace_present;
		logic [6:0] pages_valid_in;
		logic usable_in;
	} req_t;

	typedef struct packed {
		logic found;
		logic [1:0] victim_pkg;
		logic victim_die;
		logic [5:0] victim_block;
		logic trigger_gc;
	} res_t;

	// Classified request passed from front to back.
	typedef struct packed {
		logic [1:0] cmd;
		logic addr_ok;
		logic [SLOT_W-1:0] slot;
		logic [DSLOT_W-1:0] dslot;
		logic replace_present;
		logic [PV_W-1:0] pages_valid;
		logic usable;
		logic [1:0] p0;
		logic [1:0] p1m;
		logic d0;
		logic d1m;
		logic empty;
	} op_t;
endpackage

/* src/ggvs_front.sv */
// Front part: accepts requests, checks addresses and works out query bounds.
// Depends on ggvs_pkg.
module ggvs_front import ggvs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input req_t req,
	output logic op_valid,
	input logic op_stall,
	output op_t op
);
	logic full_q;
	op_t op_q;
	op_t nxt;
	logic [2:0] p_hi;
	logic [1:0] d_hi;

	// Classification of the incoming request.
	always_comb begin
		nxt = '0;
		nxt.cmd = req.cmd;
		nxt.addr_ok = ({1'b0, req.pkg_index} < 3'(PKG_COUNT))
			&& ({1'b0, req.die_index} < 2'(DIES_PER_PACKAGE))
			&& ({1'b0, req.block_index} < 7'(BLOCKS_PER_DIE));
		nxt.dslot = DSLOT_W'(req.pkg_index * DIES_PER_PACKAGE + req.die_index);
		nxt.slot = SLOT_W'((req.pkg_index * DIES_PER_PACKAGE + req.die_index)
			* BLOCKS_PER_DIE + req.block_index);
		nxt.replace_present = req.replace_present;
		nxt.pages_valid = req.pages_valid_in;
		nxt.usable = req.usable_in;
		nxt.p0 = req.any_package ? 2'd0 : req.pkg_index;
		p_hi = req.any_package ? 3'(PKG_COUNT) : ({1'b0, req.pkg_index} + 3'd1);
		if (p_hi > 3'(PKG_COUNT)) p_hi = 3'(PKG_COUNT);
		nxt.d0 = req.any_die ? 1'b0 : req.die_index;
		d_hi = req.any_die ? 2'(DIES_PER_PACKAGE) : ({1'b0, req.die_index} + 2'd1);
		if (d_hi > 2'(DIES_PER_PACKAGE)) d_hi = 2'(DIES_PER_PACKAGE);
		nxt.empty = (p_hi <= {1'b0, nxt.p0}) || (d_hi <= {1'b0, nxt.d0});
		nxt.p1m = 2'(p_hi - 3'd1);
		nxt.d1m = 1'(d_hi - 2'd1);
	end

	assign stall = full_q && op_stall;
	assign op_valid = full_q;
	assign op = op_q;

	// One-entry queue towards the back part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (!stall) begin
			full_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && valid) begin
			op_q <= nxt;
		end
	end
endmodule

/* src/ggvs_back.sv */
// Back part: holds candidate marks, valid counts and usable bits in memories,
// does status updates directly, replacing writes and commits as read-modify-write
// and queries as a scan of one block per cycle. Uses ggvs_pkg.
module ggvs_back import ggvs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic op_valid,
	output logic op_stall,
	input op_t op,
	output logic valid,
	input logic stall,
	output res_t res
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_RMW = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_LAST = 3'd4;

	// Per-block memories: candidate mark, usable bit, valid page count.
	logic mark_mem [NUM_BLOCKS];
	logic use_mem [NUM_BLOCKS];
	logic [PV_W-1:0] pv_mem [NUM_BLOCKS];
	logic [CNT_W-1:0] cnt_q [DIE_COUNT];

	logic [2:0] state_q;
	logic [SLOT_W-1:0] clr_q;
	logic out_full_q;
	res_t res_q;
	res_t res_nxt;
	logic [1:0] cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [DSLOT_W-1:0] dslot_q;
	logic [1:0] p_q, p1_q;
	logic d_q, d0_q, d1_q;
	logic [5:0] b_q;
	logic [PV_W-1:0] best_q;
	logic found_q;
	logic [1:0] vp_q;
	logic vd_q;
	logic [5:0] vb_q;
	logic mark_s1, use_s1, ok_s1;
	logic [PV_W-1:0] pv_s1;
	logic [1:0] pp_s1;
	logic pd_s1;
	logic [5:0] pb_s1;
	logic [SLOT_W-1:0] scan_slot;
	logic [SLOT_W-1:0] rd_slot;
	logic scan_last;
	logic take;
	logic out_free;
	logic needs_rmw;
	logic needs_scan;
	logic res_load;
	logic [CNT_W-1:0] cnt_new;
	logic better;

	assign out_free = !out_full_q || !stall;
	assign take = op_valid && (state_q == ST_IDLE) && out_free;
	assign op_stall = !take;
	assign valid = out_full_q;
	assign res = res_q;

	// In-range replacing writes and commits read the old mark; non-empty queries scan.
	assign needs_rmw = op.addr_ok
		&& ((op.cmd == CMD_WRITE && op.replace_present) || op.cmd == CMD_COMMIT);
	assign needs_scan = (op.cmd == CMD_QUERY) && !op.empty;
	assign res_load = (take && !needs_rmw && !needs_scan)
		|| (state_q == ST_RMW) || (state_q == ST_LAST);

	assign scan_slot = SLOT_W'((p_q * DIES_PER_PACKAGE + d_q) * BLOCKS_PER_DIE + b_q);
	assign rd_slot = (state_q == ST_SCAN) ? scan_slot : op.slot;
	assign scan_last = (b_q == 6'(BLOCKS_PER_DIE - 1)) && (d_q == d1_q) && (p_q == p1_q);
	assign cnt_new = mark_s1 ? cnt_q[dslot_q] : cnt_q[dslot_q] + CNT_W'(1);
	assign better = ok_s1 && mark_s1 && use_s1 && (pv_s1 < best_q);

	// Mark memory: cleared after reset, rewritten by writes and commits.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mark_mem[clr_q] <= 1'b0;
		end else if (state_q == ST_RMW) begin
			mark_mem[slot_q] <= (cmd_q == CMD_WRITE);
		end
		mark_s1 <= mark_mem[rd_slot];
	end

	// Usable memory: cleared after reset, written by status updates.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			use_mem[clr_q] <= 1'b0;
		end else if (take && op.cmd == CMD_STATUS && op.addr_ok) begin
			use_mem[op.slot] <= op.usable;
		end
		use_s1 <= use_mem[rd_slot];
	end

	// Valid page count memory; only used where the usable bit has been written.
	always_ff @(posedge clk) begin
		if (take && op.cmd == CMD_STATUS && op.addr_ok) begin
			pv_mem[op.slot] <= op.pages_valid;
		end
		pv_s1 <= pv_mem[rd_slot];
	end

	// Per-die candidate counts, updated in the RMW state of a write or commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIE_COUNT; i++) cnt_q[i] <= '0;
		end else if (state_q == ST_RMW) begin
			if (cmd_q == CMD_WRITE) begin
				cnt_q[dslot_q] <= cnt_new;
			end else if (mark_s1) begin
				cnt_q[dslot_q] <= cnt_q[dslot_q] - CNT_W'(1);
			end
		end
	end

	// Sequencer: clearing pass, idle, read-modify-write, scan and final compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_full_q <= 1'b0;
			ok_s1 <= 1'b0;
		end else begin
			ok_s1 <= (state_q == ST_SCAN);
			if (res_load) begin
				out_full_q <= 1'b1;
			end else if (!stall) begin
				out_full_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(NUM_BLOCKS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (take) begin
						if (needs_scan) begin
							state_q <= ST_SCAN;
						end else if (needs_rmw) begin
							state_q <= ST_RMW;
						end
					end
				end
				ST_RMW: state_q <= ST_IDLE;
				ST_SCAN: begin
					if (scan_last) state_q <= ST_LAST;
				end
				ST_LAST: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result of the current request.
	always_comb begin
		res_nxt = '0;
		case (state_q)
			ST_RMW: res_nxt.trigger_gc = (cmd_q == CMD_WRITE) && (cnt_new == CNT_W'(1));
			ST_LAST: begin
				res_nxt.found = found_q || better;
				res_nxt.victim_pkg = better ? pp_s1 : vp_q;
				res_nxt.victim_die = better ? pd_s1 : vd_q;
				res_nxt.victim_block = better ? pb_s1 : vb_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res_nxt;
	end

	// Request registers, scan position and best candidate so far.
	always_ff @(posedge clk) begin
		pp_s1 <= p_q;
		pd_s1 <= d_q;
		pb_s1 <= b_q;
		if (take) begin
			cmd_q <= op.cmd;
			slot_q <= op.slot;
			dslot_q <= op.dslot;
			p_q <= op.p0; p1_q <= op.p1m;
			d_q <= op.d0; d0_q <= op.d0; d1_q <= op.d1m;
			b_q <= '0;
			best_q <= PV_W'(PAGES_PER_BLOCK);
			found_q <= 1'b0;
			vp_q <= '0; vd_q <= 1'b0; vb_q <= '0;
		end else begin
			if (state_q == ST_SCAN) begin
				if (b_q == 6'(BLOCKS_PER_DIE - 1)) begin
					b_q <= '0;
					if (d_q == d1_q) begin
						d_q <= d0_q;
						p_q <= p_q + 2'd1;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end else begin
					b_q <= b_q + 6'd1;
				end
			end
			if (better) begin
				best_q <= pv_s1;
				found_q <= 1'b1;
				vp_q <= pp_s1; vd_q <= pd_s1; vb_q <= pb_s1;
			end
		end
	end

`ifndef SYNTH
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !take) else $error("request taken while busy");
	a_trig_only_write: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && res.trigger_gc) |-> !res.found) else $error("trigger with found");
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LAST) |=> (state_q == ST_IDLE && valid))
		else $error("scan end without result");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && stall) |=> (valid && $stable(res))) else $error("stalled result changed");
`endif
endmodule

/* src/greedy_gc_victim_selector_core.sv */
// Top level of the greedy garbage-collection victim selector.
// Instantiates ggvs_front and ggvs_back; uses ggvs_pkg.
// After reset the back part clears its mark and usable memories for all 512
// blocks; requests wait during this pass. Afterwards a status update writes its
// memories directly, and a replacing write or a commit reads the old mark, then
// rewrites it. A query scans one block per cycle over the selected packages and
// dies and then makes one final compare; the single read port of each block
// memory sets the scan rate. The front part holds one request in a registered
// queue. One request is in the back part at a time, and a result that waits
// under stall holds the back part.
module greedy_gc_victim_selector_core import ggvs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output res_t out_data
);
	logic op_valid;
	logic op_stall;
	op_t op;

	ggvs_front u_front (
		.clk(clk), .arst_n(arst_n),
		.valid(in_valid), .stall(in_stall), .req(in_data),
		.op_valid(op_valid), .op_stall(op_stall), .op(op)
	);

	ggvs_back u_back (
		.clk(clk), .arst_n(arst_n),
		.op_valid(op_valid), .op_stall(op_stall), .op(op),
		.valid(out_valid), .stall(out_stall), .res(out_data)
	);
endmodule

/* verif/tb_greedy_gc_victim_selector_core.sv */
// Testbench for the greedy garbage-collection victim selector core.
// Depends on ggvs_pkg and greedy_gc_victim_selector_core; predicts every result
// with its own copy of the candidate, valid-count and usable state.
`timescale 1ns / 1ps

module tb_greedy_gc_victim_selector_core;
	import ggvs_pkg::*;

	// Scoreboard: holds the selector state and the queue of awaited results.
	class victim_scoreboard;
		bit cand[NUM_BLOCKS];
		int die_cnt[DIE_COUNT];
		bit [6:0] pv[NUM_BLOCKS];
		bit usable[NUM_BLOCKS];
		res_t awaited[$];
		int errors;
		int n_found, n_trig, n_checked;

		function automatic res_t predict(req_t r);
			res_t o;
			int s, ds, best, p0, p1, d0, d1;
			bit ok;
			o = '0;
			ok = r.pkg_index < PKG_COUNT && r.die_index < DIES_PER_PACKAGE &&
				r.block_index < BLOCKS_PER_DIE;
			ds = r.pkg_index * DIES_PER_PACKAGE + r.die_index;
			s = ds * BLOCKS_PER_DIE + r.block_index;
			case (r.cmd)
				CMD_WRITE: begin
					if (r.replace_present && ok) begin
						if (!cand[s]) begin
							cand[s] = 1'b1;
							die_cnt[ds]++;
						end
						o.trigger_gc = die_cnt[ds] == 1;
					end
				end
				CMD_COMMIT: begin
					if (ok && cand[s]) begin
						cand[s] = 1'b0;
						die_cnt[ds]--;
					end
				end
				CMD_QUERY: begin
					p0 = r.any_package ? 0 : int'(r.pkg_index);
					p1 = r.any_package ? PKG_COUNT : int'(r.pkg_index) + 1;
					d0 = r.any_die ? 0 : int'(r.die_index);
					d1 = r.any_die ? DIES_PER_PACKAGE : int'(r.die_index) + 1;
					if (p1 > PKG_COUNT) p1 = PKG_COUNT;
					if (d1 > DIES_PER_PACKAGE) d1 = DIES_PER_PACKAGE;
					best = PAGES_PER_BLOCK;
					for (int p = p0; p < p1; p++)
						for (int d = d0; d < d1; d++)
							for (int b = 0; b < BLOCKS_PER_DIE; b++) begin
								s = (p * DIES_PER_PACKAGE + d) * BLOCKS_PER_DIE + b;
								if (cand[s] && usable[s] && int'(pv[s]) < best) begin
									best = int'(pv[s]);
									o.found = 1'b1;
									o.victim_pkg = 2'(p);
									o.victim_die = 1'(d);
									o.victim_block = 6'(b);
								end
							end
				end
				default: begin
					if (ok) begin
						pv[s] = r.pages_valid_in;
						usable[s] = r.usable_in;
					end
				end
			endcase
			return o;
		endfunction

		function void note_request(req_t r);
			awaited = {awaited, predict(r)};
		endfunction

		function void check_result(res_t got);
			res_t want;
			n_checked++;
			if (awaited.size() == 0) begin
				$display("%0t: result exp none got %p", $time, got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			n_found += int'(got.found);
			n_trig += int'(got.trigger_gc);
			if (got.found !== want.found)
				$display("%0t: found exp %0d got %0d", $time, want.found, got.found);
			if (got.victim_pkg !== want.victim_pkg)
				$display("%0t: victim_pkg exp %0d got %0d", $time, want.victim_pkg,
					got.victim_pkg);
			if (got.victim_die !== want.victim_die)
				$display("%0t: victim_die exp %0d got %0d", $time, want.victim_die,
					got.victim_die);
			if (got.victim_block !== want.victim_block)
				$display("%0t: victim_block exp %0d got %0d", $time, want.victim_block,
					got.victim_block);
			if (got.trigger_gc !== want.trigger_gc)
				$display("%0t: trigger_gc exp %0d got %0d", $time, want.trigger_gc,
					got.trigger_gc);
			if (got !== want) errors++;
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1;
	res_t out_data;

	victim_scoreboard sb = new();
	int idle_cycles = 0;
	int n_sent = 0;

	greedy_gc_victim_selector_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Sample on the rising edge; count cycles with no progress for the watchdog.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sb.note_request(in_data);
			n_sent++;
		end
		if (out_valid && !out_stall) sb.check_result(out_data);
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout after %0d cycles without progress", idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: random stall lengths, with runs of no stall at all.
	initial begin
		int gap;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				out_stall <= 1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Hand one request over and wait until it is taken.
	task automatic send_request(req_t r, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic req_t make_req(bit [1:0] c, bit [1:0] p, bit d, bit [5:0] b);
		req_t r;
		r = '0;
		r.cmd = c;
		r.pkg_index = p;
		r.die_index = d;
		r.block_index = b;
		return r;
	endfunction

	function automatic req_t noise_req();
		req_t r;
		r = req_t'($urandom);
		r.pages_valid_in = 7'($urandom_range(0, 64));
		return r;
	endfunction

	initial begin
		req_t r;
		bit burst;
		int k;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part: extremes and each special case.
		r = make_req(CMD_QUERY, 2'd0, 1'b0, 6'd0); r.any_package = 1; r.any_die = 1;
		send_request(r, 0);
		r = make_req(CMD_WRITE, 2'd3, 1'b1, 6'd63); send_request(r, 0);
		r.replace_present = 1; send_request(r, 0);
		send_request(r, 0);
		r = make_req(CMD_WRITE, 2'd3, 1'b1, 6'd0); r.replace_present = 1; send_request(r, 0);
		r = make_req(CMD_STATUS, 2'd3, 1'b1, 6'd63); r.pages_valid_in = 64; r.usable_in = 1;
		send_request(r, 0);
		r = make_req(CMD_QUERY, 2'd3, 1'b1, 6'd0); send_request(r, 0);
		r = make_req(CMD_STATUS, 2'd3, 1'b1, 6'd0); r.pages_valid_in = 0; r.usable_in = 1;
		send_request(r, 0);
		r = make_req(CMD_QUERY, 2'd3, 1'b1, 6'd0); send_request(r, 0);
		r = make_req(CMD_STATUS, 2'd3, 1'b1, 6'd0); r.pages_valid_in = 127;
		send_request(r, 0);
		r = make_req(CMD_QUERY, 2'd0, 1'b0, 6'd0); r.any_package = 1; send_request(r, 0);
		r.any_die = 1; send_request(r, 0);
		r = make_req(CMD_STATUS, 2'd3, 1'b1, 6'd63); r.pages_valid_in = 63;
		send_request(r, 0);
		r = make_req(CMD_QUERY, 2'd3, 1'b0, 6'd0); r.any_die = 1; send_request(r, 0);
		r = make_req(CMD_COMMIT, 2'd0, 1'b0, 6'd0); send_request(r, 0);
		r = make_req(CMD_COMMIT, 2'd3, 1'b1, 6'd63); send_request(r, 0);
		r = make_req(CMD_QUERY, 2'd3, 1'b1, 6'd0); send_request(r, 0);
		r = make_req(CMD_COMMIT, 2'd3, 1'b1, 6'd0); send_request(r, 0);

		// Random part: mostly small package subsets so queries find victims.
		k = 0;
		while (k < 1150) begin
			burst = $urandom_range(0, 7) == 0;
			r = noise_req();
			if ($urandom_range(0, 9) != 0) begin
				r.pkg_index = 2'($urandom_range(0, 1));
				r.block_index = ($urandom_range(0, 7) == 0) ? 6'($urandom)
					: 6'($urandom_range(0, 7));
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						r.cmd = CMD_WRITE;
						r.replace_present = $urandom_range(0, 4) != 0;
					end
					3: r.cmd = CMD_COMMIT;
					4, 5: r.cmd = CMD_QUERY;
					default: begin
						r.cmd = CMD_STATUS;
						r.usable_in = $urandom_range(0, 4) != 0;
					end
				endcase
				if (r.cmd == CMD_QUERY && $urandom_range(0, 3) != 0) r.any_package = 0;
			end
			send_request(r, burst);
			k++;
		end
		in_valid <= 0;

		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("Sent %0d requests, checked %0d results (%0d victims found, %0d triggers).",
			n_sent, sb.n_checked, sb.n_found, sb.n_trig);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

/* filelist.f */
src/ggvs_pkg.sv
src/ggvs_front.sv
src/ggvs_back.sv
src/greedy_gc_victim_selector_core.sv
verif/tb_greedy_gc_victim_selector_core.sv
